// ===== rtl/m3i_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package m3i_pkg;

  localparam int ELEM_W = 32;     // element width, in and out
  localparam int N_ELEM = 9;      // elements per matrix
  localparam int COF_W = 64;      // cofactor width (exact)
  localparam int DET_W = 97;      // signed determinant width (exact)
  localparam int DMAG_W = 96;     // determinant magnitude width
  localparam int QB = 33;         // quotient bits kept before saturation

  localparam int COF_STAGES = 2;
  localparam int DET_STAGES = 4;
  localparam int DIV_STAGES = 2 + QB + 1;
  localparam int PIPE_DEPTH = COF_STAGES + DET_STAGES + DIV_STAGES;

  localparam logic [QB-1:0] MAG_POS_MAX = 33'h07FFFFFFF;
  localparam logic [QB-1:0] MAG_NEG_MAX = 33'h080000000;
  localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFFFFFF;
  localparam logic [ELEM_W-1:0] SAT_NEG = 32'h80000000;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0] cof_t;

  typedef struct packed {
    elem_t m_xx;
    elem_t m_xy;
    elem_t m_xz;
    elem_t m_yx;
    elem_t m_yy;
    elem_t m_yz;
    elem_t m_zx;
    elem_t m_zy;
    elem_t m_zz;
  } m3i_in_t;

  typedef struct packed {
    elem_t inv_xx;
    elem_t inv_xy;
    elem_t inv_xz;
    elem_t inv_yx;
    elem_t inv_yy;
    elem_t inv_yz;
    elem_t inv_zx;
    elem_t inv_zy;
    elem_t inv_zz;
    logic  singular;
    logic  overflowed;
  } m3i_out_t;

  // determinant as the divider lanes consume it
  typedef struct packed {
    logic [DMAG_W-1:0] dmag;
    logic              dneg;
    logic              zero;
  } det_info_t;

endpackage

`default_nettype wire

// ===== rtl/m3i_cofactor.sv =====
// Cofactor stages: eighteen 32x32 products, then nine differences.
// Depends on m3i_pkg.
`default_nettype none

module m3i_cofactor (
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire m3i_pkg::m3i_in_t m,
  output m3i_pkg::cof_t         cof [m3i_pkg::N_ELEM],
  output m3i_pkg::elem_t        row [3]
);
  import m3i_pkg::*;

  cof_t  prod [2*N_ELEM];
  elem_t row1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      prod[0]  <= m.m_yy * m.m_zz;  prod[1]  <= m.m_yz * m.m_zy;
      prod[2]  <= m.m_xz * m.m_zy;  prod[3]  <= m.m_xy * m.m_zz;
      prod[4]  <= m.m_xy * m.m_yz;  prod[5]  <= m.m_xz * m.m_yy;
      prod[6]  <= m.m_yz * m.m_zx;  prod[7]  <= m.m_yx * m.m_zz;
      prod[8]  <= m.m_xx * m.m_zz;  prod[9]  <= m.m_xz * m.m_zx;
      prod[10] <= m.m_xz * m.m_yx;  prod[11] <= m.m_xx * m.m_yz;
      prod[12] <= m.m_yx * m.m_zy;  prod[13] <= m.m_yy * m.m_zx;
      prod[14] <= m.m_xy * m.m_zx;  prod[15] <= m.m_xx * m.m_zy;
      prod[16] <= m.m_xx * m.m_yy;  prod[17] <= m.m_xy * m.m_yx;
      row1[0] <= m.m_xx;
      row1[1] <= m.m_xy;
      row1[2] <= m.m_xz;
      for (int j = 0; j < N_ELEM; j++) begin
        cof[j] <= prod[2*j] - prod[2*j+1];
      end
      row <= row1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/m3i_det.sv =====
// Determinant stages: split 32x64 products, term sums, total, magnitude.
// Depends on m3i_pkg; delays the cofactors to stay aligned.
`default_nettype none

module m3i_det (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire m3i_pkg::cof_t     cof_in [m3i_pkg::N_ELEM],
  input  wire m3i_pkg::elem_t    row [3],
  output m3i_pkg::cof_t          cof_out [m3i_pkg::N_ELEM],
  output m3i_pkg::det_info_t     det
);
  import m3i_pkg::*;

  logic signed [63:0]      ph [3];
  logic signed [64:0]      pl [3];
  logic signed [DET_W-1:0] term [3];
  logic signed [DET_W-1:0] total;
  logic [DET_W-1:0]        neg_total;
  cof_t                    cd [DET_STAGES-1][N_ELEM];

  assign neg_total = -total;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 3; t++) begin
        ph[t]   <= row[t] * $signed(cof_in[3*t][63:32]);
        pl[t]   <= row[t] * $signed({1'b0, cof_in[3*t][31:0]});
        term[t] <= {ph[t][63], ph[t], 32'b0} + {{32{pl[t][64]}}, pl[t]};
      end
      total    <= term[0] + term[1] + term[2];
      det.dneg <= total[DET_W-1];
      det.zero <= (total == '0);
      det.dmag <= total[DET_W-1] ? neg_total[DMAG_W-1:0] : total[DMAG_W-1:0];
      cd[0]   <= cof_in;
      for (int s = 1; s < DET_STAGES - 1; s++) begin
        cd[s] <= cd[s-1];
      end
      cof_out <= cd[DET_STAGES-2];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/m3i_div.sv =====
// Nine restoring-division lanes, one quotient bit per stage, sharing the
// determinant; then rounding and saturation. Depends on m3i_pkg.
`default_nettype none

module m3i_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire m3i_pkg::cof_t     cof [m3i_pkg::N_ELEM],
  input  wire m3i_pkg::det_info_t det,
  output m3i_pkg::m3i_out_t      res
);
  import m3i_pkg::*;

  localparam int NW = COF_W + 2*FRAC_BITS + 1;
  localparam int CW = (NW > DMAG_W) ? NW : DMAG_W;

  typedef struct packed {
    logic [DMAG_W-1:0] rem;
    logic [QB-1:0]     low;
    logic [QB-1:0]     q;
    logic              neg;
    logic              ovf;
  } lane_t;

  // first prep stage: magnitudes and result signs
  logic [COF_W-1:0]  cm [N_ELEM];
  logic              sg [N_ELEM];
  logic [COF_W-1:0]  neg_cof [N_ELEM];
  det_info_t         det1;

  // per division stage
  lane_t             st [QB+1][N_ELEM];
  det_info_t         dt [QB+1];

  logic [NW-1:0]     num [N_ELEM];
  logic [CW-1:0]     r0 [N_ELEM];

  always_comb begin
    for (int l = 0; l < N_ELEM; l++) begin
      neg_cof[l] = -cof[l];
      num[l]     = {cm[l], {(NW-COF_W){1'b0}}};
      r0[l]      = CW'(num[l] >> QB);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det1  <= det;
      dt[0] <= det1;
      for (int l = 0; l < N_ELEM; l++) begin
        cm[l] <= cof[l][COF_W-1] ? neg_cof[l] : cof[l];
        sg[l] <= cof[l][COF_W-1] ^ det.dneg;
        st[0][l].ovf <= (r0[l] >= CW'(det1.dmag));
        st[0][l].rem <= r0[l][DMAG_W-1:0];
        st[0][l].low <= num[l][QB-1:0];
        st[0][l].q   <= '0;
        st[0][l].neg <= sg[l];
      end
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    lane_t             nx [N_ELEM];
    logic [DMAG_W:0]   tr [N_ELEM];

    always_comb begin
      for (int l = 0; l < N_ELEM; l++) begin
        tr[l]     = {st[s][l].rem, st[s][l].low[QB-1]};
        nx[l]     = st[s][l];
        nx[l].low = st[s][l].low << 1;
        if (tr[l] >= {1'b0, dt[s].dmag}) begin
          nx[l].rem = DMAG_W'(tr[l] - {1'b0, dt[s].dmag});
          nx[l].q   = {st[s][l].q[QB-2:0], 1'b1};
        end else begin
          nx[l].rem = tr[l][DMAG_W-1:0];
          nx[l].q   = {st[s][l].q[QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[s+1] <= nx;
        dt[s+1] <= dt[s];
      end
    end
  end

  // rounding: half of (q + 1), then clamp to the 32-bit range
  logic [QB:0]       qq [N_ELEM];
  logic [QB-1:0]     mag [N_ELEM];
  logic [ELEM_W-1:0] val [N_ELEM];
  logic [N_ELEM-1:0] sat;

  always_comb begin
    for (int l = 0; l < N_ELEM; l++) begin
      qq[l]  = {1'b0, st[QB][l].q} + (QB+1)'(1);
      mag[l] = qq[l][QB:1];
      if (st[QB][l].neg) begin
        sat[l] = st[QB][l].ovf || (mag[l] > MAG_NEG_MAX);
        val[l] = sat[l] ? SAT_NEG : -mag[l][ELEM_W-1:0];
      end else begin
        sat[l] = st[QB][l].ovf || (mag[l] > MAG_POS_MAX);
        val[l] = sat[l] ? SAT_POS : mag[l][ELEM_W-1:0];
      end
      if (dt[QB].zero) begin
        val[l] = '0;
        sat[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.inv_xx     <= val[0];
      res.inv_xy     <= val[1];
      res.inv_xz     <= val[2];
      res.inv_yx     <= val[3];
      res.inv_yy     <= val[4];
      res.inv_yz     <= val[5];
      res.inv_zx     <= val[6];
      res.inv_zy     <= val[7];
      res.inv_zz     <= val[8];
      res.singular   <= dt[QB].zero;
      res.overflowed <= |sat;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/matrix3x3_inverse_top.sv =====
// Top level of the 3x3 matrix inverse pipeline (adjugate over determinant).
// Depends on m3i_pkg, m3i_cofactor, m3i_det and m3i_div.
`default_nettype none

// One 3x3 matrix of signed fixed-point elements (FRAC_BITS fraction bits)
// enters per transaction and one inverse leaves per transaction, with a
// singular flag (determinant exactly zero, all elements zero) and an
// overflowed flag (some element clamped to the 32-bit range). Each element
// is the exact quotient cofactor / determinant rounded to nearest, ties
// away from zero. Throughput is one transaction per cycle when not stalled;
// PIPE_DEPTH counts two cofactor stages, four determinant stages, two
// divider prep stages, 33 restoring-division stages (one quotient bit each,
// nine lanes sharing the determinant) and one rounding/output register.
// The whole pipeline advances together: while a result sits unaccepted in
// the output register, every stage holds and item_ready is low.
module matrix3x3_inverse_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire m3i_pkg::m3i_in_t  item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output m3i_pkg::m3i_out_t      result
);
  import m3i_pkg::*;

  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld;

  cof_t      cof_a [N_ELEM];
  elem_t     row   [3];
  cof_t      cof_b [N_ELEM];
  det_info_t det;

  // hold everything only when the output register is full and not taken
  assign adv          = !(vld[PIPE_DEPTH-1] && !result_ready);
  assign item_ready   = adv;
  assign result_valid = vld[PIPE_DEPTH-1];

  // valid bits advance in lockstep with the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], item_valid};
    end
  end

  m3i_cofactor u_cof (
    .clk (clk),
    .adv (adv),
    .m   (item),
    .cof (cof_a),
    .row (row)
  );

  m3i_det u_det (
    .clk     (clk),
    .adv     (adv),
    .cof_in  (cof_a),
    .row     (row),
    .cof_out (cof_b),
    .det     (det)
  );

  m3i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .adv (adv),
    .cof (cof_b),
    .det (det),
    .res (result)
  );

  // a singular matrix yields all zeros and never reports overflow; five elements are checked
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.singular |->
      !result.overflowed && result.inv_xx == '0 && result.inv_yy == '0 &&
      result.inv_zz == '0 && result.inv_xz == '0 && result.inv_zx == '0)
    else $error("singular result carries nonzero data");

  // overflow means at least one element sits at a range limit
  a_ovf_clamped: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.overflowed |->
      result.inv_xx == SAT_POS || result.inv_xx == SAT_NEG ||
      result.inv_xy == SAT_POS || result.inv_xy == SAT_NEG ||
      result.inv_xz == SAT_POS || result.inv_xz == SAT_NEG ||
      result.inv_yx == SAT_POS || result.inv_yx == SAT_NEG ||
      result.inv_yy == SAT_POS || result.inv_yy == SAT_NEG ||
      result.inv_yz == SAT_POS || result.inv_yz == SAT_NEG ||
      result.inv_zx == SAT_POS || result.inv_zx == SAT_NEG ||
      result.inv_zy == SAT_POS || result.inv_zy == SAT_NEG ||
      result.inv_zz == SAT_POS || result.inv_zz == SAT_NEG)
    else $error("overflow flagged without a clamped element");

  // a stall freezes every in-flight transaction
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ===== verif/matrix3x3_inverse_top_tb.sv =====
// Self-checking testbench for matrix3x3_inverse_top: directed table, then random matrices.
// Depends on m3i_pkg and the block's RTL; expected inverses come from typed rows or a local predictor.
module matrix3x3_inverse_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import m3i_pkg::*;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 1900;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 20;
  localparam int PAUSE_AT = 700;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  m3i_in_t item;
  logic result_valid;
  logic result_ready = 1'b0;
  m3i_out_t result;

  // typed expectation travels alongside the item it belongs to
  logic item_typed;
  m3i_out_t item_typed_inv;

  typedef struct {
    m3i_in_t m;
    bit typed;
    m3i_out_t inv;
  } dir_row_t;

  dir_row_t dir_rows[$];
  m3i_out_t pending_inv[$];
  int errors = 0;
  int cycles = 0;

  matrix3x3_inverse_top #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact adjugate over determinant, rounded to nearest with ties away from zero.
  function automatic m3i_out_t invert(m3i_in_t m);
    cof_t a, b, c, d, e, f, g, h, k;
    cof_t adj[9];
    logic signed [127:0] det;
    logic [127:0] dmag, num, q;
    logic [63:0] cm;
    logic dneg, neg, ovf;
    elem_t el[9];
    m3i_out_t r;
    a = m.m_xx; b = m.m_xy; c = m.m_xz;
    d = m.m_yx; e = m.m_yy; f = m.m_yz;
    g = m.m_zx; h = m.m_zy; k = m.m_zz;
    // cofactors wrap at 64 bits, as the datapath does
    adj[0] = e * k - f * h;
    adj[1] = c * h - b * k;
    adj[2] = b * f - c * e;
    adj[3] = f * g - d * k;
    adj[4] = a * k - c * g;
    adj[5] = c * d - a * f;
    adj[6] = d * h - e * g;
    adj[7] = b * g - a * h;
    adj[8] = a * e - b * d;
    det = 128'(a) * 128'(adj[0]) + 128'(b) * 128'(adj[3]) + 128'(c) * 128'(adj[6]);
    dneg = det[127];
    dmag = dneg ? -det : det;
    ovf = 1'b0;
    if (dmag == 0) begin
      r = '0;
      r.singular = 1'b1;
      return r;
    end
    for (int j = 0; j < 9; j++) begin
      cm = adj[j][63] ? -adj[j] : adj[j];
      if (cm == 0) begin
        el[j] = '0;
      end else begin
        num = {64'b0, cm} << (2 * FRAC + 1);
        q = ((num / dmag) + 1) >> 1;
        neg = adj[j][63] != dneg;
        if (neg) begin
          if (q > 128'h80000000) begin
            ovf = 1'b1;
            el[j] = SAT_NEG;
          end else begin
            el[j] = -q[31:0];
          end
        end else if (q > 128'h7FFFFFFF) begin
          ovf = 1'b1;
          el[j] = SAT_POS;
        end else begin
          el[j] = q[31:0];
        end
      end
    end
    r = {el[0], el[1], el[2], el[3], el[4], el[5], el[6], el[7], el[8], 1'b0, ovf};
    return r;
  endfunction

  function automatic m3i_in_t mat(elem_t a, elem_t b, elem_t c, elem_t d, elem_t e,
                                  elem_t f, elem_t g, elem_t h, elem_t k);
    return {a, b, c, d, e, f, g, h, k};
  endfunction

  function automatic m3i_out_t inv_of(elem_t a, elem_t b, elem_t c, elem_t d, elem_t e,
                                      elem_t f, elem_t g, elem_t h, elem_t k,
                                      logic sing, logic ovf);
    return {a, b, c, d, e, f, g, h, k, sing, ovf};
  endfunction

  function automatic elem_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return 32'sd0;
      1: return 32'sd1;
      2: return -32'sd1;
      3: return SAT_POS;
      4: return SAT_NEG;
      default: return $urandom;
    endcase
  endfunction

  function automatic elem_t small_val(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mix of matrix flavors: wild bit patterns, small values, well-conditioned ones, mixed magnitudes, extremes.
  function automatic m3i_in_t random_matrix();
    elem_t v[9];
    int flavor;
    flavor = $urandom_range(0, 9);
    for (int j = 0; j < 9; j++) begin
      case (flavor)
        0, 1, 2: v[j] = $urandom;
        3, 4, 5: v[j] = small_val(3 * ONE);
        6: v[j] = (j % 4 == 0) ? ONE * $urandom_range(1, 8) + small_val(ONE / 4)
                               : small_val(ONE / 2);
        7: v[j] = small_val(1 << $urandom_range(4, 30));
        8: v[j] = pick_extreme();
        default: v[j] = small_val(4);
      endcase
    end
    // for some, overwrite row three with row one, each element copied or negated at random
    if (flavor == 7 && $urandom_range(0, 1)) begin
      for (int j = 0; j < 3; j++) v[6 + j] = $urandom_range(0, 1) ? v[j] : -v[j];
    end
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, want %h", field, got, want);
    errors++;
  endtask

  // Sample handshakes at the falling edge, once everything has settled.
  always @(negedge clk) begin
    m3i_out_t want;
    if (!rst && item_valid && item_ready)
      pending_inv.push_back(item_typed ? item_typed_inv : invert(item));
    if (!rst && result_valid && result_ready) begin
      if (pending_inv.size() == 0) begin
        $display("mismatch: unexpected result transaction");
        errors++;
      end else begin
        want = pending_inv.pop_front();
        if (result.inv_xx !== want.inv_xx) report("inv_xx", result.inv_xx, want.inv_xx);
        if (result.inv_xy !== want.inv_xy) report("inv_xy", result.inv_xy, want.inv_xy);
        if (result.inv_xz !== want.inv_xz) report("inv_xz", result.inv_xz, want.inv_xz);
        if (result.inv_yx !== want.inv_yx) report("inv_yx", result.inv_yx, want.inv_yx);
        if (result.inv_yy !== want.inv_yy) report("inv_yy", result.inv_yy, want.inv_yy);
        if (result.inv_yz !== want.inv_yz) report("inv_yz", result.inv_yz, want.inv_yz);
        if (result.inv_zx !== want.inv_zx) report("inv_zx", result.inv_zx, want.inv_zx);
        if (result.inv_zy !== want.inv_zy) report("inv_zy", result.inv_zy, want.inv_zy);
        if (result.inv_zz !== want.inv_zz) report("inv_zz", result.inv_zz, want.inv_zz);
        if (result.singular !== want.singular)
          report("singular", 32'(result.singular), 32'(want.singular));
        if (result.overflowed !== want.overflowed)
          report("overflowed", 32'(result.overflowed), 32'(want.overflowed));
      end
    end
  end

  // Receiver: drive result_ready from a randomly re-picked stall pattern.
  always @(posedge clk) begin
    int ready_mode;
    if (cycles % 64 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= ($urandom_range(0, 1) == 1);
      2: result_ready <= ($urandom_range(0, 4) == 0);
      default: result_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix3x3_inverse_top regression: fail");
      $finish;
    end
  end

  // Drive one transaction; returns at the posedge right after acceptance.
  task automatic send(m3i_in_t m, bit typed, m3i_out_t inv, int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= m;
    item_typed <= typed;
    item_typed_inv <= inv;
    item_valid <= 1'b1;
    do @(negedge clk); while (!item_ready);
    @(posedge clk);
  endtask

  initial begin
    m3i_out_t none;
    dir_row_t row;
    int burst_left;
    int gap;
    none = '0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    item_typed = 1'b0;
    item_typed_inv = '0;

    // directed rows; the typed ones are readable at a glance
    dir_rows.push_back('{mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, inv_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0)});
    dir_rows.push_back('{mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1,
                         inv_of(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0)});
    dir_rows.push_back('{mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1,
                         inv_of(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, 0, 0)});
    dir_rows.push_back('{mat(2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE), 1,
                         inv_of(ONE / 2, 0, 0, 0, ONE / 2, 0, 0, 0, ONE / 2, 0, 0)});
    // all-equal matrices have rank one
    dir_rows.push_back('{mat(SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS,
                             SAT_POS, SAT_POS), 1, inv_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0)});
    dir_rows.push_back('{mat(SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG,
                             SAT_NEG, SAT_NEG), 1, inv_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0)});
    // tiny diagonal: inverse far out of range, clamp both ways
    dir_rows.push_back('{mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1,
                         inv_of(SAT_POS, 0, 0, 0, SAT_POS, 0, 0, 0, SAT_POS, 0, 1)});
    dir_rows.push_back('{mat(-1, 0, 0, 0, -1, 0, 0, 0, -1), 1,
                         inv_of(SAT_NEG, 0, 0, 0, SAT_NEG, 0, 0, 0, SAT_NEG, 0, 1)});
    // rest go through the predictor
    dir_rows.push_back('{mat(3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, -3 * ONE), 0, none});
    dir_rows.push_back('{mat(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 0, none});
    dir_rows.push_back('{mat(SAT_POS, 0, 0, 0, SAT_POS, 0, 0, 0, SAT_POS), 0, none});
    dir_rows.push_back('{mat(SAT_NEG, 0, 0, 0, SAT_NEG, 0, 0, 0, SAT_NEG), 0, none});
    dir_rows.push_back('{mat(SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG,
                             SAT_POS, SAT_POS), 0, none});
    dir_rows.push_back('{mat(SAT_NEG, SAT_NEG, 0, SAT_NEG, SAT_POS, 0, 0, 0, SAT_NEG), 0, none});
    dir_rows.push_back('{mat(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE,
                             8 * ONE, 10 * ONE), 0, none});
    dir_rows.push_back('{mat(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE,
                             8 * ONE, 9 * ONE), 0, none});
    dir_rows.push_back('{mat(2, 0, 0, 0, 2, 0, 0, 0, 2), 0, none});
    dir_rows.push_back('{mat(3, 1, 0, 1, 3, 1, 0, 1, 3), 0, none});
    dir_rows.push_back('{mat(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F,
                             32'hF0F0F0F0, 32'h33333333, 32'hCCCCCCCC, 32'h00FF00FF,
                             32'hFF00FF00), 0, none});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send(row.m, row.typed, row.inv, $urandom_range(0, 2));
    end

    // random part in bursts; occasionally a long stretch with no gaps
    burst_left = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      gap = 0;
      if (i == PAUSE_AT) begin
        // hold off until the pipeline has drained completely
        item_valid <= 1'b0;
        while (pending_inv.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      if (burst_left == 0) begin
        gap = $urandom_range(1, 9);
        burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 30);
      end
      burst_left--;
      send(random_matrix(), 1'b0, none, gap);
    end
    item_valid <= 1'b0;

    while (pending_inv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("matrix3x3_inverse_top regression: pass");
    end else begin
      $display("matrix3x3_inverse_top regression: fail");
    end
    $finish;
  end
endmodule
